FILE: sv/interval_booking_table_macros.svh
// assertion macros for the interval booking table
`ifndef INTERVAL_BOOKING_TABLE_MACROS_SVH
`define INTERVAL_BOOKING_TABLE_MACROS_SVH

// same-cycle implication, checked outside reset
`define IBT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define IBT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/ibt_pkg.sv
// shared types and constants of the interval booking table
`timescale 1ns / 1ps

package ibt_pkg;

    localparam int TIME_W           = 31;
    localparam int MAX_BOOKINGS_DEF = 64;

    // result codes
    typedef enum logic [1:0] {
        ST_BOOKED  = 2'd0,
        ST_OVERLAP = 2'd1,
        ST_FULL    = 2'd2,
        ST_INVALID = 2'd3
    } status_t;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SEARCH,
        S_PROBE,
        S_PRED_START,
        S_PRED_END,
        S_SUCC_RD,
        S_SUCC,
        S_ROOM,
        S_SHIFT,
        S_INSERT,
        S_RESULT
    } state_t;

    // compare unit flags
    typedef struct packed {
        logic lt;
        logic eq;
    } cmp_res_t;

    // result handed from sequencer to output stage
    typedef struct packed {
        logic    done;
        status_t code;
    } res_t;

endpackage

FILE: sv/ibt_cmp.sv
// shared magnitude compare unit
`timescale 1ns / 1ps

module ibt_cmp
    import ibt_pkg::*;
(
    input  logic [TIME_W-1:0] a,
    input  logic [TIME_W-1:0] b,
    output cmp_res_t          res
);

    // a < b and a == b
    always_comb
    begin
        res.lt = (a < b);
        res.eq = (a == b);
    end

endmodule

FILE: sv/ibt_mem.sv
// interval table memory, one write and one registered read per cycle
`timescale 1ns / 1ps

module ibt_mem
    import ibt_pkg::*;
#(
    parameter int DEPTH = MAX_BOOKINGS_DEF,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [TIME_W-1:0] rd_start,
    output logic [TIME_W-1:0] rd_end,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [TIME_W-1:0] wr_start,
    input  logic [TIME_W-1:0] wr_end
);

    logic [2*TIME_W-1:0] mem [DEPTH];
    logic [2*TIME_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_start, wr_end};
        end
    end

    // read port, data holds when not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_start = rd_data_reg[2*TIME_W-1:TIME_W];
    assign rd_end   = rd_data_reg[TIME_W-1:0];

endmodule

FILE: sv/ibt_ctrl.sv
// sequencer: validity check, binary search, neighbor checks, shift and insert
`timescale 1ns / 1ps

module ibt_ctrl
    import ibt_pkg::*;
#(
    parameter int MAX_BOOKINGS = MAX_BOOKINGS_DEF,
    parameter int AW           = $clog2(MAX_BOOKINGS),
    parameter int CW           = $clog2(MAX_BOOKINGS + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic [TIME_W-1:0] req_start,
    input  logic [TIME_W-1:0] req_end,
    input  logic              res_ready,
    output logic              busy,
    output res_t              res,
    output logic              mem_rd_en,
    output logic [AW-1:0]     mem_rd_addr,
    input  logic [TIME_W-1:0] mem_rd_start,
    input  logic [TIME_W-1:0] mem_rd_end,
    output logic              mem_wr_en,
    output logic [AW-1:0]     mem_wr_addr,
    output logic [TIME_W-1:0] mem_wr_start,
    output logic [TIME_W-1:0] mem_wr_end
);

    state_t            state_reg, state_next;
    logic [TIME_W-1:0] s_reg, s_next;
    logic [TIME_W-1:0] e_reg, e_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     lo_reg, lo_next;
    logic [CW-1:0]     hi_reg, hi_next;
    logic [CW-1:0]     mid_reg, mid_next;
    logic [AW-1:0]     src_reg, src_next;
    logic [AW-1:0]     dst_reg, dst_next;
    status_t           code_reg, code_next;

    logic [TIME_W-1:0] cmp_a, cmp_b;
    cmp_res_t          cmp;
    logic [CW-1:0]     mid_calc;
    logic [CW-1:0]     pos_m1;
    logic [CW-1:0]     count_m1;

    ibt_cmp u_cmp (
        .a   (cmp_a),
        .b   (cmp_b),
        .res (cmp)
    );

    assign mid_calc = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign pos_m1   = lo_reg - CW'(1);
    assign count_m1 = count_reg - CW'(1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (cmp.lt || cmp.eq)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    state_next = S_PROBE;
                end
                else if (lo_reg != '0)
                begin
                    state_next = S_PRED_START;
                end
                else
                begin
                    state_next = S_SUCC_RD;
                end
            end
            S_PROBE:
            begin
                state_next = S_SEARCH;
            end
            S_PRED_START:
            begin
                state_next = cmp.eq ? S_RESULT : S_PRED_END;
            end
            S_PRED_END:
            begin
                state_next = cmp.lt ? S_RESULT : S_SUCC_RD;
            end
            S_SUCC_RD:
            begin
                state_next = (lo_reg < count_reg) ? S_SUCC : S_ROOM;
            end
            S_SUCC:
            begin
                state_next = cmp.lt ? S_RESULT : S_ROOM;
            end
            S_ROOM:
            begin
                if (count_reg == CW'(MAX_BOOKINGS))
                begin
                    state_next = S_RESULT;
                end
                else if (count_reg > lo_reg)
                begin
                    state_next = S_SHIFT;
                end
                else
                begin
                    state_next = S_INSERT;
                end
            end
            S_SHIFT:
            begin
                if (CW'(src_reg) == lo_reg)
                begin
                    state_next = S_INSERT;
                end
            end
            S_INSERT:
            begin
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs, compare operands and datapath updates
    always_comb
    begin
        s_next       = s_reg;
        e_next       = e_reg;
        count_next   = count_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        src_next     = src_reg;
        dst_next     = dst_reg;
        code_next    = code_reg;
        cmp_a        = s_reg;
        cmp_b        = mem_rd_start;
        mem_rd_en    = 1'b0;
        mem_rd_addr  = lo_reg[AW-1:0];
        mem_wr_en    = 1'b0;
        mem_wr_addr  = dst_reg;
        mem_wr_start = mem_rd_start;
        mem_wr_end   = mem_rd_end;
        busy         = (state_reg != S_IDLE);
        res.done     = 1'b0;
        res.code     = code_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    s_next = req_start;
                    e_next = req_end;
                end
            end
            // end not after start is invalid
            S_CHECK:
            begin
                cmp_a   = e_reg;
                cmp_b   = s_reg;
                lo_next = '0;
                hi_next = count_reg;
                if (cmp.lt || cmp.eq)
                begin
                    code_next = ST_INVALID;
                end
            end
            // issue a probe, or read the predecessor once the slot is found
            S_SEARCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = mid_calc[AW-1:0];
                    mid_next    = mid_calc;
                end
                else if (lo_reg != '0)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = pos_m1[AW-1:0];
                end
            end
            // s < start of probed entry narrows to the lower half
            S_PROBE:
            begin
                cmp_a = s_reg;
                cmp_b = mem_rd_start;
                if (cmp.lt)
                begin
                    hi_next = mid_reg;
                end
                else
                begin
                    lo_next = mid_reg + CW'(1);
                end
            end
            // predecessor shares the start
            S_PRED_START:
            begin
                cmp_a = mem_rd_start;
                cmp_b = s_reg;
                if (cmp.eq)
                begin
                    code_next = ST_OVERLAP;
                end
            end
            // predecessor ends after new start
            S_PRED_END:
            begin
                cmp_a = s_reg;
                cmp_b = mem_rd_end;
                if (cmp.lt)
                begin
                    code_next = ST_OVERLAP;
                end
            end
            S_SUCC_RD:
            begin
                if (lo_reg < count_reg)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = lo_reg[AW-1:0];
                end
            end
            // successor starts before new end
            S_SUCC:
            begin
                cmp_a = mem_rd_start;
                cmp_b = e_reg;
                if (cmp.lt)
                begin
                    code_next = ST_OVERLAP;
                end
            end
            // room check, prime the shift with the last entry
            S_ROOM:
            begin
                if (count_reg == CW'(MAX_BOOKINGS))
                begin
                    code_next = ST_FULL;
                end
                else if (count_reg > lo_reg)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = count_m1[AW-1:0];
                    src_next    = count_m1[AW-1:0];
                    dst_next    = count_reg[AW-1:0];
                end
            end
            // move one entry up per cycle, reading the next one down
            S_SHIFT:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = dst_reg;
                if (CW'(src_reg) != lo_reg)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = src_reg - AW'(1);
                    src_next    = src_reg - AW'(1);
                    dst_next    = dst_reg - AW'(1);
                end
            end
            S_INSERT:
            begin
                mem_wr_en    = 1'b1;
                mem_wr_addr  = lo_reg[AW-1:0];
                mem_wr_start = s_reg;
                mem_wr_end   = e_reg;
                count_next   = count_reg + CW'(1);
                code_next    = ST_BOOKED;
            end
            S_RESULT:
            begin
                res.done = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        s_reg    <= s_next;
        e_reg    <= e_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        mid_reg  <= mid_next;
        src_reg  <= src_next;
        dst_reg  <= dst_next;
        code_reg <= code_next;
    end

endmodule

FILE: sv/interval_booking_table.sv
// Validity check (an invalid interval goes straight to the result), binary search of the n
// stored entries for the slot in up to ceil(log2(n+1)) probes, overlap checks against the
// predecessor and successor where present, shift of the entries from the slot up, insert.
// Throughput: one request at a time; the next is taken in the cycle after the result is
// handed to the output register. Search probes and the entry shift share one memory read port.
// Reset clears the sequencer, entry count and output valid; the table needs no clearing.
`timescale 1ns / 1ps
`include "interval_booking_table_macros.svh"

module interval_booking_table
    import ibt_pkg::*;
#(
    parameter int MAX_BOOKINGS = MAX_BOOKINGS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [TIME_W-1:0] start_time,
    input  logic [TIME_W-1:0] end_time,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        status
);

    localparam int AW = $clog2(MAX_BOOKINGS);
    localparam int CW = $clog2(MAX_BOOKINGS + 1);

    logic              busy;
    res_t              res;
    logic              res_ready;
    logic              load;
    logic              out_valid_reg, out_valid_next;
    status_t           status_reg, status_next;

    logic              mem_rd_en;
    logic [AW-1:0]     mem_rd_addr;
    logic [TIME_W-1:0] mem_rd_start;
    logic [TIME_W-1:0] mem_rd_end;
    logic              mem_wr_en;
    logic [AW-1:0]     mem_wr_addr;
    logic [TIME_W-1:0] mem_wr_start;
    logic [TIME_W-1:0] mem_wr_end;

    ibt_ctrl #(
        .MAX_BOOKINGS (MAX_BOOKINGS),
        .AW           (AW),
        .CW           (CW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (in_valid),
        .req_start    (start_time),
        .req_end      (end_time),
        .res_ready    (res_ready),
        .busy         (busy),
        .res          (res),
        .mem_rd_en    (mem_rd_en),
        .mem_rd_addr  (mem_rd_addr),
        .mem_rd_start (mem_rd_start),
        .mem_rd_end   (mem_rd_end),
        .mem_wr_en    (mem_wr_en),
        .mem_wr_addr  (mem_wr_addr),
        .mem_wr_start (mem_wr_start),
        .mem_wr_end   (mem_wr_end)
    );

    ibt_mem #(
        .DEPTH (MAX_BOOKINGS),
        .AW    (AW)
    ) u_mem (
        .clk      (clk),
        .rd_en    (mem_rd_en),
        .rd_addr  (mem_rd_addr),
        .rd_start (mem_rd_start),
        .rd_end   (mem_rd_end),
        .wr_en    (mem_wr_en),
        .wr_addr  (mem_wr_addr),
        .wr_start (mem_wr_start),
        .wr_end   (mem_wr_end)
    );

    // request side stalls while a request is in work
    assign in_stall = busy;

    // output register takes a result when empty or being drained
    assign res_ready = !out_valid_reg || !out_stall;
    assign load      = res.done && res_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            status_next    = res.code;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;

    // checks
    `IBT_ASSERT_NEXT(a_busy_after_req, clk, rst_n, in_valid && !in_stall, in_stall, "not busy")
    `IBT_ASSERT_NEXT(a_load_shows, clk, rst_n, load, out_valid && status == $past(res.code), "lost")
    `IBT_ASSERT_NEXT(a_drain_clears, clk, rst_n, out_valid_reg && !out_stall && !load, !out_valid, "repeat")
    `IBT_ASSERT_NOW(a_idle_no_result, clk, rst_n, !in_stall, !res.done, "result from idle sequencer")

endmodule
